FILE: hw/rtl/lmm_pkg.sv
// Shared types, constants and the channel compare helper for the line morphology block.
// Used by every module under hw/rtl; depends on nothing else.
package lmm_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_RADIUS_DEF = 15;
    localparam int MAX_LINE_DEF   = 4096;

    // Configuration port shape
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 1'b1;

    // Mode codes
    localparam logic MODE_DILATE = 1'b0;
    localparam logic MODE_ERODE  = 1'b1;

    // Window limit field: a tap offset up to 2 * 15, the largest 4-bit radius
    localparam int LIM_W = 6;

    localparam logic [7:0] CHAN_MAX = 8'd255;

    typedef struct packed {
        logic [7:0] in_alpha;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic       last_in_line;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_alpha;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       end_of_line;
    } out_beat_t;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // One window evaluation handed from the controller to the lanes
    typedef struct packed {
        logic             valid;
        logic [LIM_W-1:0] limit;
        logic             eol;
        logic             mode;
    } job_t;

    // Control that travels beside the lane data through the merge stages
    typedef struct packed {
        logic valid;
        logic eol;
        logic mode;
    } stage_ctl_t;

    typedef enum logic {
        ST_RUN,
        ST_FLUSH
    } lmm_state_t;

    // Neutral pixel: loses every compare in the given mode
    function automatic pixel_t lmm_ident(input logic mode);
        logic [7:0] v;
        v = (mode == MODE_ERODE) ? CHAN_MAX : 8'd0;
        return '{alpha: v, red: v, green: v, blue: v};
    endfunction

    function automatic logic [7:0] lmm_pick8(input logic mode, input logic [7:0] a,
                                             input logic [7:0] b);
        logic a_wins;
        a_wins = (mode == MODE_ERODE) ? (a < b) : (a > b);
        return a_wins ? a : b;
    endfunction

    // Per-channel maximum (dilate) or minimum (erode)
    function automatic pixel_t lmm_pick(input logic mode, input pixel_t a, input pixel_t b);
        pixel_t r;
        r.alpha = lmm_pick8(mode, a.alpha, b.alpha);
        r.red   = lmm_pick8(mode, a.red,   b.red);
        r.green = lmm_pick8(mode, a.green, b.green);
        r.blue  = lmm_pick8(mode, a.blue,  b.blue);
        return r;
    endfunction

endpackage

FILE: hw/rtl/line_morphology_min_max.sv
// A result passes the lane, group and output registers after the beat or flush step owing it.
// Throughput, while out_ready holds: one pixel per cycle inside a line, set by the lane and merge
// pipeline; a line's last pixel then flushes up to radius more results, one per cycle, taking no pixel.
// Reset: counters, mode (dilate) and radius (0) clear; the pipeline empties; the tap line is
// not cleared, since taps from before a line's first pixel are masked by the lanes.
// Top level: ties the controller, the tap lanes and the merge tree; depends on lmm_pkg.
module line_morphology_min_max #(
    parameter int MAX_RADIUS = lmm_pkg::MAX_RADIUS_DEF,
    parameter int MAX_LINE   = lmm_pkg::MAX_LINE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lmm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lmm_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  lmm_pkg::in_beat_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output lmm_pkg::out_beat_t            out_data
);

    localparam int DEPTH = 2 * MAX_RADIUS + 1;

    logic                shift;
    logic                lane_free;
    logic                take;
    lmm_pkg::job_t       job;
    lmm_pkg::stage_ctl_t s1_ctl;
    lmm_pkg::pixel_t     pix;
    lmm_pkg::pixel_t     lane [DEPTH];

    assign pix = '{alpha: in_data.in_alpha, red: in_data.in_red,
                   green: in_data.in_green, blue: in_data.in_blue};

    lmm_ctrl #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_LINE   (MAX_LINE)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_last   (in_data.last_in_line),
        .lane_free (lane_free),
        .in_ready  (in_ready),
        .shift     (shift),
        .job       (job)
    );

    lmm_lanes #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_lanes (
        .clk    (clk),
        .rst_n  (rst_n),
        .shift  (shift),
        .pix    (pix),
        .job    (job),
        .take   (take),
        .free   (lane_free),
        .s1_ctl (s1_ctl),
        .lane   (lane)
    );

    lmm_merge #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_ctl    (s1_ctl),
        .lane      (lane),
        .take      (take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: hw/rtl/lmm_ctrl.sv
// Line controller: configuration registers, pixel counters and the end-of-line flush sequencer.
// Issues one window job per owed result. Depends on lmm_pkg.
module lmm_ctrl #(
    parameter int MAX_RADIUS = lmm_pkg::MAX_RADIUS_DEF,
    parameter int MAX_LINE   = lmm_pkg::MAX_LINE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lmm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lmm_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic                          in_valid,
    input  logic                          in_last,
    input  logic                          lane_free,
    output logic                          in_ready,
    output logic                          shift,
    output lmm_pkg::job_t                 job
);

    localparam int RAD_W = $clog2(MAX_RADIUS + 1);
    localparam int CNT_W = $clog2(MAX_LINE);
    localparam int CMP_W = ((CNT_W > lmm_pkg::LIM_W) ? CNT_W : lmm_pkg::LIM_W) + 1;

    logic                          mode_reg;
    logic [lmm_pkg::CFG_DAT_W-1:0] radius_reg;
    lmm_pkg::lmm_state_t           state_reg, state_next;
    logic [CNT_W-1:0]              recv_reg, recv_next;
    logic [CNT_W-1:0]              emitted_reg, emitted_next;
    logic [RAD_W-1:0]              line_rad_reg, line_rad_next;
    logic [RAD_W-1:0]              flush_d_reg, flush_d_next;
    logic [CNT_W-1:0]              flush_i_reg, flush_i_next;

    logic [RAD_W-1:0] rad_sat;
    logic [RAD_W-1:0] rad_eff;
    logic [CNT_W-1:0] emit_eff;
    logic [CNT_W-1:0] gap;
    logic             line_start;
    logic             last;
    logic             accept;
    logic             steady_due;
    logic [CMP_W-1:0] cur_d, cur_i, cur_r, span, limit;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= lmm_pkg::MODE_DILATE;
            radius_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lmm_pkg::REG_MODE:   mode_reg   <= cfg_data[0];
                lmm_pkg::REG_RADIUS: radius_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Saturate radius to what the window holds
    assign rad_sat = (int'(radius_reg) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius_reg);

    // Line bookkeeping for the beat on the input
    assign line_start = (recv_reg == '0);
    assign rad_eff    = line_start ? rad_sat : line_rad_reg;
    assign emit_eff   = line_start ? '0 : emitted_reg;
    assign gap        = recv_reg - emit_eff;
    assign last       = in_last || (recv_reg == CNT_W'(MAX_LINE - 1));
    assign steady_due = (CMP_W'(gap) >= CMP_W'(rad_eff));

    assign in_ready = (state_reg == lmm_pkg::ST_RUN) && lane_free;
    assign accept   = in_valid && in_ready;
    assign shift    = accept;

    // Window reach: taps 0 .. min(distance + radius, index)
    always_comb
    begin
        if (state_reg == lmm_pkg::ST_FLUSH)
        begin
            cur_d = CMP_W'(flush_d_reg);
            cur_i = CMP_W'(flush_i_reg);
            cur_r = CMP_W'(line_rad_reg);
        end
        else
        begin
            cur_d = CMP_W'(gap);
            cur_i = CMP_W'(recv_reg);
            cur_r = CMP_W'(rad_eff);
        end
        span  = cur_d + cur_r;
        limit = (span < cur_i) ? span : cur_i;
    end

    // Advance state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lmm_pkg::ST_RUN;
            recv_reg     <= '0;
            emitted_reg  <= '0;
            line_rad_reg <= '0;
            flush_d_reg  <= '0;
            flush_i_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            recv_reg     <= recv_next;
            emitted_reg  <= emitted_next;
            line_rad_reg <= line_rad_next;
            flush_d_reg  <= flush_d_next;
            flush_i_reg  <= flush_i_next;
        end
    end

    // Next state and job issue
    always_comb
    begin
        state_next    = state_reg;
        recv_next     = recv_reg;
        emitted_next  = emitted_reg;
        line_rad_next = line_rad_reg;
        flush_d_next  = flush_d_reg;
        flush_i_next  = flush_i_reg;
        job.valid     = 1'b0;
        job.eol       = 1'b0;
        job.mode      = mode_reg;
        job.limit     = limit[lmm_pkg::LIM_W-1:0];

        unique case (state_reg)
            lmm_pkg::ST_RUN:
            begin
                if (accept)
                begin
                    line_rad_next = rad_eff;
                    if (last)
                    begin
                        job.valid    = 1'b1;
                        job.eol      = (gap == '0);
                        recv_next    = '0;
                        emitted_next = '0;
                        if (gap != '0)
                        begin
                            state_next   = lmm_pkg::ST_FLUSH;
                            flush_d_next = RAD_W'(gap - CNT_W'(1));
                            flush_i_next = recv_reg;
                        end
                    end
                    else
                    begin
                        job.valid    = steady_due;
                        recv_next    = recv_reg + CNT_W'(1);
                        emitted_next = emit_eff + CNT_W'(steady_due);
                    end
                end
            end
            lmm_pkg::ST_FLUSH:
            begin
                if (lane_free)
                begin
                    job.valid = 1'b1;
                    job.eol   = (flush_d_reg == '0);
                    if (flush_d_reg == '0)
                        state_next = lmm_pkg::ST_RUN;
                    else
                        flush_d_next = flush_d_reg - RAD_W'(1);
                end
            end
            default: state_next = lmm_pkg::ST_RUN;
        endcase
    end

    // A job never reaches past twice the line radius
    a_limit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        job.valid |-> (CMP_W'(job.limit) <= (cur_r << 1)))
        else $error("window limit beyond twice the radius");

    // Emitted results never run ahead of received pixels
    a_emit_behind: assert property (@(posedge clk) disable iff (!rst_n)
        emitted_reg <= recv_reg)
        else $error("emitted count ahead of received count");

    // The final result of a line closes it
    a_eol_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (job.valid && job.eol) |=> (state_reg == lmm_pkg::ST_RUN) && (recv_reg == '0))
        else $error("line not closed after its final result");

endmodule

FILE: hw/rtl/lmm_lanes.sv
// Tap line of the last 2*MAX_RADIUS+1 pixels and one masking lane per tap.
// Each lane registers its pixel or the neutral value. Depends on lmm_pkg.
module lmm_lanes #(
    parameter int MAX_RADIUS = lmm_pkg::MAX_RADIUS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  lmm_pkg::pixel_t     pix,
    input  lmm_pkg::job_t       job,
    input  logic                take,
    output logic                free,
    output lmm_pkg::stage_ctl_t s1_ctl,
    output lmm_pkg::pixel_t     lane [2*MAX_RADIUS+1]
);

    localparam int DEPTH = 2 * MAX_RADIUS + 1;

    lmm_pkg::pixel_t     taps_reg [DEPTH];
    lmm_pkg::pixel_t     lane_reg [DEPTH];
    lmm_pkg::pixel_t     tap_src  [DEPTH];
    lmm_pkg::stage_ctl_t s1_ctl_reg;
    lmm_pkg::pixel_t     ident;

    assign free   = !s1_ctl_reg.valid || take;
    assign s1_ctl = s1_ctl_reg;
    assign ident  = lmm_pkg::lmm_ident(job.mode);

    // Shift the new pixel into the tap line
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            taps_reg[0] <= pix;
            for (int k = 1; k < DEPTH; k++)
                taps_reg[k] <= taps_reg[k-1];
        end
    end

    // Lanes see the line as it stands after this beat
    assign tap_src[0] = shift ? pix : taps_reg[0];
    for (genvar k = 1; k < DEPTH; k++)
    begin : g_src
        assign tap_src[k] = shift ? taps_reg[k-1] : taps_reg[k];
    end

    // Mask taps outside the window and register each lane
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_lane
        always_ff @(posedge clk)
        begin
            if (free)
                lane_reg[k] <= (int'(job.limit) >= k) ? tap_src[k] : ident;
        end
        assign lane[k] = lane_reg[k];
    end

    // Hold lane-stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_ctl_reg <= '0;
        else if (free)
            s1_ctl_reg <= '{valid: job.valid, eol: job.eol, mode: job.mode};
    end

endmodule

FILE: hw/rtl/lmm_merge.sv
// Merge tree: folds the lanes into groups of four, then the groups into one result beat.
// The group results are registered, and the output register holds the beat. Depends on lmm_pkg.
module lmm_merge #(
    parameter int MAX_RADIUS = lmm_pkg::MAX_RADIUS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lmm_pkg::stage_ctl_t s1_ctl,
    input  lmm_pkg::pixel_t     lane [2*MAX_RADIUS+1],
    output logic                take,
    output logic                out_valid,
    input  logic                out_ready,
    output lmm_pkg::out_beat_t  out_data
);

    localparam int DEPTH = 2 * MAX_RADIUS + 1;
    localparam int NG    = (DEPTH + 3) / 4;

    lmm_pkg::pixel_t     part_reg  [NG];
    lmm_pkg::pixel_t     part_next [NG];
    lmm_pkg::stage_ctl_t s2_ctl_reg;
    lmm_pkg::out_beat_t  out_reg;
    logic                out_valid_reg;
    logic                en_out;
    lmm_pkg::pixel_t     total;

    assign en_out    = !out_valid_reg || out_ready;
    assign take      = !s2_ctl_reg.valid || en_out;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Fold each group of four lanes
    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            part_next[g] = lane[4*g];
            for (int j = 1; j < 4; j++)
            begin
                if (4*g + j < DEPTH)
                    part_next[g] = lmm_pkg::lmm_pick(s1_ctl.mode, part_next[g], lane[4*g + j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            part_reg <= part_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_ctl_reg <= '0;
        else if (take)
            s2_ctl_reg <= s1_ctl;
    end

    // Fold the group results
    always_comb
    begin
        total = part_reg[0];
        for (int g = 1; g < NG; g++)
            total = lmm_pkg::lmm_pick(s2_ctl_reg.mode, total, part_reg[g]);
    end

    // Hold the result beat until taken
    always_ff @(posedge clk)
    begin
        if (en_out)
            out_reg <= '{out_alpha: total.alpha, out_red: total.red, out_green: total.green,
                         out_blue: total.blue, end_of_line: s2_ctl_reg.eol};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en_out)
            out_valid_reg <= s2_ctl_reg.valid;
    end

endmodule

FILE: dv/line_morphology_min_max_tb.sv
// Self-checking testbench for line_morphology_min_max: pixel lines in, per-channel max/min out.
// Holds its own scoreboard and window predictor; depends on lmm_pkg and the block's RTL.
`timescale 1ns / 1ps

module line_morphology_min_max_tb;

    localparam int TAP_DEPTH  = 2 * lmm_pkg::MAX_RADIUS_DEF + 1;
    localparam int HOLD_BEATS = 300;
    localparam int SETTLE     = 8;
    localparam int RAND_GOAL  = 340;
    localparam int LONG_LINE  = 48;

    // Predicts the window results of every accepted pixel and checks them in order
    class lmm_scoreboard;
        lmm_pkg::pixel_t    taps[TAP_DEPTH];
        int unsigned        pix_seen;
        int unsigned        pix_done;
        int unsigned        line_r;
        logic               mode_q;
        logic [3:0]         radius_q;
        lmm_pkg::out_beat_t owed_q[$];
        int                 errors;

        function new();
            pix_seen = 0;
            pix_done = 0;
            line_r   = 0;
            mode_q   = lmm_pkg::MODE_DILATE;
            radius_q = '0;
            errors   = 0;
        endfunction

        function void write_reg(logic [lmm_pkg::CFG_IDX_W-1:0] idx,
                                logic [lmm_pkg::CFG_DAT_W-1:0] data);
            if (idx == lmm_pkg::REG_MODE)
                mode_q = data[0];
            else if (idx == lmm_pkg::REG_RADIUS)
                radius_q = data[3:0];
        endfunction

        function int outstanding();
            return owed_q.size();
        endfunction

        // Max or min over taps lo..hi of the current line, clipped at both ends
        function lmm_pkg::out_beat_t window_result(int unsigned x, int unsigned top, bit eol);
            int unsigned        lo;
            int unsigned        hi;
            logic [7:0]         acc[4];
            logic [7:0]         v;
            lmm_pkg::pixel_t    p;
            lmm_pkg::out_beat_t r;
            lo = (x >= line_r) ? x - line_r : 0;
            hi = (x + line_r < top) ? x + line_r : top;
            for (int c = 0; c < 4; c++)
                acc[c] = (mode_q == lmm_pkg::MODE_ERODE) ? 8'hFF : 8'h00;
            for (int unsigned j = lo; j <= hi; j++)
            begin
                p = taps[j % TAP_DEPTH];
                for (int c = 0; c < 4; c++)
                begin
                    v = p[31 - 8 * c -: 8];
                    if (mode_q == lmm_pkg::MODE_ERODE ? (v < acc[c]) : (v > acc[c]))
                        acc[c] = v;
                end
            end
            r.out_alpha   = acc[0];
            r.out_red     = acc[1];
            r.out_green   = acc[2];
            r.out_blue    = acc[3];
            r.end_of_line = eol;
            return r;
        endfunction

        // Record one accepted pixel and queue the results it owes
        function void note_pixel(lmm_pkg::in_beat_t b);
            bit closes;
            if (pix_seen == 0)
            begin
                line_r   = (radius_q > lmm_pkg::MAX_RADIUS_DEF) ? lmm_pkg::MAX_RADIUS_DEF
                                                                : radius_q;
                pix_done = 0;
            end
            taps[pix_seen % TAP_DEPTH] = lmm_pkg::pixel_t'(b[32:1]);
            closes = b.last_in_line || (pix_seen + 1 >= lmm_pkg::MAX_LINE_DEF);
            if (!closes)
            begin
                if (pix_done + line_r <= pix_seen)
                begin
                    owed_q.push_back(window_result(pix_done, pix_seen, 1'b0));
                    pix_done++;
                end
                pix_seen++;
            end
            else
            begin
                for (int unsigned x = pix_done; x <= pix_seen; x++)
                    owed_q.push_back(window_result(x, pix_seen, x == pix_seen));
                pix_seen = 0;
                pix_done = 0;
            end
        endfunction

        function void field_check(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // Compare one output beat against the oldest owed result
        function void check_result(lmm_pkg::out_beat_t got);
            lmm_pkg::out_beat_t want;
            if (owed_q.size() == 0)
            begin
                $error("out_data: no result owed, got %h", got);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            field_check("out_alpha",   want.out_alpha,   got.out_alpha);
            field_check("out_red",     want.out_red,     got.out_red);
            field_check("out_green",   want.out_green,   got.out_green);
            field_check("out_blue",    want.out_blue,    got.out_blue);
            field_check("end_of_line", 8'(want.end_of_line), 8'(got.end_of_line));
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [lmm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [lmm_pkg::CFG_DAT_W-1:0] cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    lmm_pkg::in_beat_t             in_data;
    logic                          out_valid;
    logic                          out_ready;
    lmm_pkg::out_beat_t            out_data;

    lmm_scoreboard     sb;
    lmm_pkg::in_beat_t pix_queue[$];
    int                pushed;
    int                accepted;
    bit                in_idle_en;
    bit                out_idle_en;
    bit                hold_req;

    line_morphology_min_max uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Bound the run
    initial
    begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offer queued pixels, idling at random; hold each beat until it is taken
    initial
    begin
        in_valid = 1'b0;
        in_data  = '0;
        forever
        begin
            @(negedge clk);
            if (pix_queue.size() != 0 && !(in_idle_en && $urandom_range(99) < 29))
            begin
                in_valid <= 1'b1;
                in_data  <= pix_queue.pop_front();
                do @(posedge clk); while (!in_ready);
                sb.note_pixel(in_data);
                accepted++;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Stall the output at random, or for a long stretch on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_BEATS) @(negedge clk);
                hold_req = 1'b0;
            end
            out_ready <= !(out_idle_en && $urandom_range(99) < 29);
        end
    end

    // Check every output beat
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    function automatic lmm_pkg::pixel_t rand_pixel();
        lmm_pkg::pixel_t p;
        logic [7:0]      base;
        p    = lmm_pkg::pixel_t'($urandom);
        base = 8'($urandom);
        case ($urandom_range(3))
            1: p = lmm_pkg::pixel_t'({{8{p.alpha[0]}}, {8{p.red[0]}},
                                      {8{p.green[0]}}, {8{p.blue[0]}}});
            2: p = lmm_pkg::pixel_t'({base ^ {5'd0, p.alpha[2:0]}, base ^ {5'd0, p.red[2:0]},
                                      base ^ {5'd0, p.green[2:0]}, base ^ {5'd0, p.blue[2:0]}});
            default: ;
        endcase
        return p;
    endfunction

    task automatic push_pixel(input lmm_pkg::pixel_t p, input bit last);
        pix_queue.push_back(lmm_pkg::in_beat_t'({p, last}));
        pushed++;
    endtask

    task automatic push_run(input int n, input bit closes);
        for (int i = 0; i < n; i++)
            push_pixel(rand_pixel(), closes && (i == n - 1));
    endtask

    // Wait until every pixel is taken and every owed result is out, then let the pipe settle
    task automatic drain();
        while (accepted != pushed || sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [lmm_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= lmm_pkg::CFG_DAT_W'(val);
        @(posedge clk);
        sb.write_reg(idx, lmm_pkg::CFG_DAT_W'(val));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic mode, input int unsigned r);
        write_reg(lmm_pkg::REG_MODE, {31'd0, mode});
        write_reg(lmm_pkg::REG_RADIUS, r);
    endtask

    initial
    begin
        int          rand_items;
        int          phase;
        int unsigned r;
        int          n;
        int          cut;
        sb          = new();
        pushed      = 0;
        accepted    = 0;
        hold_req    = 1'b0;
        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        rst_n       = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Pass-through: single-pixel line, then extremes
        set_config(lmm_pkg::MODE_DILATE, 0);
        push_pixel(lmm_pkg::pixel_t'(32'hFFFF_FFFF), 1'b1);
        push_pixel(lmm_pkg::pixel_t'(32'h0000_0000), 1'b0);
        push_pixel(lmm_pkg::pixel_t'(32'hFFFF_FFFF), 1'b0);
        push_pixel(lmm_pkg::pixel_t'(32'h00FF_00FF), 1'b1);
        drain();

        // Radius wider than the line: every output spans the whole line
        set_config(lmm_pkg::MODE_ERODE, 15);
        push_pixel(lmm_pkg::pixel_t'(32'hFF00_FF00), 1'b0);
        push_pixel(lmm_pkg::pixel_t'(32'h00FF_00FF), 1'b0);
        push_pixel(lmm_pkg::pixel_t'(32'hFFFF_FFFF), 1'b0);
        push_pixel(lmm_pkg::pixel_t'(32'h1234_5678), 1'b1);
        drain();

        // Mode and radius rewritten mid-line: mode acts at once, radius on the next line
        set_config(lmm_pkg::MODE_DILATE, 2);
        push_run(3, 1'b0);
        drain();
        set_config(lmm_pkg::MODE_ERODE, 5);
        push_run(3, 1'b1);
        push_run(4, 1'b1);
        drain();

        // Long line under a long output stall: the pipe fills and holds off the input
        set_config(logic'($urandom_range(1)), $urandom_range(15));
        hold_req = 1'b1;
        push_run(LONG_LINE, 1'b1);
        drain();

        // Random lines under varying settings, a few with a mid-line rewrite
        rand_items = 0;
        phase      = 0;
        while (rand_items < RAND_GOAL)
        begin
            in_idle_en  = !(phase >= 4 && phase <= 7);
            out_idle_en = in_idle_en;
            case ($urandom_range(3))
                0: r = 0;
                1: r = 15;
                default: r = $urandom_range(1, 14);
            endcase
            set_config(logic'($urandom_range(1)), r);
            repeat ($urandom_range(1, 4))
            begin
                n = ($urandom_range(7) == 0) ? $urandom_range(1, 60)
                                             : $urandom_range(1, 2 * r + 6);
                if (n > 1 && $urandom_range(7) == 0)
                begin
                    cut = $urandom_range(1, n - 1);
                    push_run(cut, 1'b0);
                    drain();
                    set_config(logic'($urandom_range(1)), $urandom_range(15));
                    push_run(n - cut, 1'b1);
                end
                else
                    push_run(n, 1'b1);
                rand_items += n;
            end
            drain();
            phase++;
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
